@@ design/tch_pkg.sv @@
// Shared types and constants for the two-table cuckoo hash set.
// Field widths, request codes and the slot layout kept in each table RAM.
// No dependencies.
`timescale 1ns / 1ps

package tch_pkg;

    localparam int KEY_W      = 31;
    localparam int OP_W       = 2;
    localparam int SLOT_W     = 4;
    localparam int DIGIT_W    = 4;
    localparam int DIGIT_BASE = 10;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_t;

endpackage

@@ design/tch_if.sv @@
// Valid/ready channels of the cuckoo hash set: request and response.
// Depends on tch_pkg for field widths.
`timescale 1ns / 1ps

interface tch_req_if import tch_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface tch_rsp_if import tch_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic              which_table;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output found, output which_table, output slot_index,
                    input ready);
    modport sink   (input valid, input found, input which_table, input slot_index,
                    output ready);
endinterface

@@ design/tch_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 11
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/tch_div.sv @@
// Shared residue unit for the hash set: remainder of a key by one of two constant moduli.
// Works one nibble per cycle, most significant first. Depends on tch_pkg for the key width.
`timescale 1ns / 1ps

module tch_div import tch_pkg::*; #(
    parameter int MOD_A = 11,
    parameter int MOD_B = 10,
    parameter int RW    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             sel_b,
    input  logic [KEY_W-1:0] dividend,
    output logic             done,
    output logic [RW-1:0]    remainder
);

    localparam int NIB_W = 4;
    localparam int STEPS = (KEY_W + NIB_W - 1) / NIB_W;
    localparam int SW    = STEPS * NIB_W;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int YW    = RW + NIB_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sel_reg, sel_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [SW-1:0] val_reg, val_next;
    logic [YW-1:0] y;
    logic [YW-1:0] sub;

    function automatic logic [YW-1:0] multiple(input logic use_b, input int k);
        return use_b ? YW'(k * MOD_B) : YW'(k * MOD_A);
    endfunction

    assign y = {rem_reg, val_reg[SW-1 -: NIB_W]};

    // y stays below 16 times the modulus, so one of 15 constant multiples fits
    always_comb
    begin
        sub = '0;
        for (int k = 1; k < (1 << NIB_W); k++)
        begin
            if (y >= multiple(sel_reg, k))
            begin
                sub = multiple(sel_reg, k);
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sel_next  = sel_reg;
        rem_next  = rem_reg;
        val_next  = val_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(STEPS);
            sel_next  = sel_b;
            rem_next  = '0;
            val_next  = SW'(dividend);
        end
        else if (busy_reg)
        begin
            rem_next = RW'(y - sub);
            val_next = {val_reg[SW-NIB_W-1:0], {NIB_W{1'b0}}};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        rem_reg <= rem_next;
        val_reg <= val_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ design/two_table_cuckoo_hash.sv @@
// Two-table cuckoo hash set: request channel in, one response beat per request.
// Depends on tch_pkg, tch_if, tch_ram and tch_div.
// -----------------------------------------------------------------------------
// Usage:
//   req carries op (insert, remove, search; the unused code acts as search) and
//   a 31-bit key. rsp returns found, which_table and slot_index, describing the
//   key as it stood before the request.
// Timing:
//   After reset the block sweeps both table RAMs clear, one slot per cycle;
//   req.ready stays low during the sweep.
//   Each request runs two residues on one shared nibble-serial unit (key mod
//   TABLE_SLOTS, then key mod 10), then a RAM read and a lookup, then the
//   response is loaded into the output register. An insert that displaces an
//   occupant runs one more residue for the occupant before the response.
//   req.ready is high only in the idle state between requests: a new request
//   is not taken until the last one has reached the output register.
// Stall:
//   The response sits in an output register. The next request is taken while it
//   waits; a finished response holds inside until rsp.ready frees the register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_table_cuckoo_hash import tch_pkg::*; #(
    parameter int TABLE_SLOTS = 11
) (
    input  logic     clk,
    input  logic     rst_n,
    tch_req_if.sink  req,
    tch_rsp_if.source rsp
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int DW = (IW > DIGIT_W) ? IW : DIGIT_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_H1    = 8'b0000_0100,
        S_M10   = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_LOOK  = 8'b0010_0000,
        S_K10   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [IW-1:0]    clr_reg, clr_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] occ_reg, occ_next;
    logic [IW-1:0]    h1_reg, h1_next;
    logic [IW-1:0]    h2_reg, h2_next;
    logic             found_reg, found_next;
    logic             tbl_reg, tbl_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             rsp_found_reg, rsp_found_next;
    logic             rsp_tbl_reg, rsp_tbl_next;
    logic [SLOT_W-1:0] rsp_idx_reg, rsp_idx_next;

    logic             div_start;
    logic             div_sel;
    logic [KEY_W-1:0] div_dividend;
    logic             div_done;
    logic [DW-1:0]    div_rem;

    logic             t1_we, t2_we;
    logic [IW-1:0]    t1_waddr, t2_waddr;
    slot_t            t1_wdata, t2_wdata;
    slot_t            t1_rdata, t2_rdata;

    logic [DIGIT_W-1:0]   rem_digit;
    logic [DIGIT_W-1:0]   neg_digit;
    logic [IW-1:0]        h2_calc;
    logic                 hit1, hit2;
    logic [IW+SLOT_W-1:0] idx_ext;

    function automatic logic [IW-1:0] second_slot(input logic [DIGIT_W-1:0] digit);
        logic [IW-1:0] slot;
        slot = '0;
        for (int d = 1; d < DIGIT_BASE; d++)
        begin
            if (digit == DIGIT_W'(d))
            begin
                slot = IW'((TABLE_SLOTS * d) / DIGIT_BASE);
            end
        end
        return slot;
    endfunction

    tch_div #(.MOD_A(TABLE_SLOTS), .MOD_B(DIGIT_BASE), .RW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .sel_b     (div_sel),
        .dividend  (div_dividend),
        .done      (div_done),
        .remainder (div_rem)
    );

    tch_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_SLOTS)) u_first_table (
        .clk   (clk),
        .we    (t1_we),
        .waddr (t1_waddr),
        .wdata (t1_wdata),
        .raddr (h1_reg),
        .rdata (t1_rdata)
    );

    tch_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_SLOTS)) u_second_table (
        .clk   (clk),
        .we    (t2_we),
        .waddr (t2_waddr),
        .wdata (t2_wdata),
        .raddr (h2_reg),
        .rdata (t2_rdata)
    );

    // 9*key mod 10 equals the negated last decimal digit
    assign rem_digit = div_rem[DIGIT_W-1:0];
    assign neg_digit = (rem_digit == '0) ? '0 : DIGIT_W'(DIGIT_BASE) - rem_digit;
    assign h2_calc   = second_slot(neg_digit);

    assign hit1 = t1_rdata.valid && (t1_rdata.key == key_reg);
    assign hit2 = t2_rdata.valid && (t2_rdata.key == key_reg);

    assign idx_ext = {{SLOT_W{1'b0}}, idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        occ_next       = occ_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        found_next     = found_reg;
        tbl_next       = tbl_reg;
        idx_next       = idx_reg;
        rsp_found_next = rsp_found_reg;
        rsp_tbl_next   = rsp_tbl_reg;
        rsp_idx_next   = rsp_idx_reg;
        div_start      = 1'b0;
        div_sel        = 1'b1;
        div_dividend   = key_reg;
        t1_we          = 1'b0;
        t1_waddr       = h1_reg;
        t1_wdata       = '0;
        t2_we          = 1'b0;
        t2_waddr       = h2_reg;
        t2_wdata       = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                t1_we    = 1'b1;
                t2_we    = 1'b1;
                t1_waddr = clr_reg;
                t2_waddr = clr_reg;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IW'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.op;
                    key_next     = req.key;
                    div_start    = 1'b1;
                    div_sel      = 1'b0;
                    div_dividend = req.key;
                    state_next   = S_H1;
                end
            end
            S_H1:
            begin
                if (div_done)
                begin
                    h1_next    = div_rem[IW-1:0];
                    div_start  = 1'b1;
                    state_next = S_M10;
                end
            end
            S_M10:
            begin
                if (div_done)
                begin
                    h2_next    = h2_calc;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                found_next = hit1 || hit2;
                tbl_next   = !hit1 && hit2;
                idx_next   = hit1 ? h1_reg : (hit2 ? h2_reg : '0);
                state_next = S_DONE;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!hit1 && !hit2)
                        begin
                            t1_we    = 1'b1;
                            t1_wdata = '{valid: 1'b1, key: key_reg};
                            if (t1_rdata.valid)
                            begin
                                occ_next     = t1_rdata.key;
                                div_start    = 1'b1;
                                div_dividend = t1_rdata.key;
                                state_next   = S_K10;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit1)
                        begin
                            t1_we = 1'b1;
                        end
                        else if (hit2)
                        begin
                            t2_we = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_K10:
            begin
                if (div_done)
                begin
                    t2_we      = 1'b1;
                    t2_waddr   = h2_calc;
                    t2_wdata   = '{valid: 1'b1, key: occ_reg};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_found_next = found_reg;
                    rsp_tbl_next   = tbl_reg;
                    rsp_idx_next   = idx_ext[SLOT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        occ_reg       <= occ_next;
        h1_reg        <= h1_next;
        h2_reg        <= h2_next;
        found_reg     <= found_next;
        tbl_reg       <= tbl_next;
        idx_reg       <= idx_next;
        rsp_found_reg <= rsp_found_next;
        rsp_tbl_reg   <= rsp_tbl_next;
        rsp_idx_reg   <= rsp_idx_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_found_reg;
    assign rsp.which_table = rsp_tbl_reg;
    assign rsp.slot_index  = rsp_idx_reg;

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for two_table_cuckoo_hash: directed and random insert/remove/search
// traffic checked beat by beat against an in-bench model of both hash tables.
// Depends on tch_pkg, tch_if and the two_table_cuckoo_hash RTL.
`timescale 1ns / 1ps

module testbench;
    import tch_pkg::*;

    localparam int TABLE_SLOTS    = 11;
    localparam int DIGIT_SCALE    = 9;
    localparam int RESET_CYCLES   = 6;
    localparam int LONG_HOLD      = 600;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 16;
    localparam int RANDOM_ITEMS   = 950;
    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};
    localparam longint unsigned  KEY_SPAN  = 64'd2147483648;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    typedef struct packed {
        logic              found;
        logic              which_table;
        logic [SLOT_W-1:0] slot_index;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    tch_req_if req ();
    tch_rsp_if rsp ();

    two_table_cuckoo_hash #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    slot_t          first_slots[TABLE_SLOTS];
    slot_t          second_slots[TABLE_SLOTS];
    lookup_result_t pending_results[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int error_count;
    int burst_left;
    bit sender_steady;
    int stall_mode;
    int stall_phase;
    int hold_req_seq;
    int hold_ack_seq;
    int hold_left;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned first_hash(logic [KEY_W-1:0] key);
        return key % TABLE_SLOTS;
    endfunction

    function automatic int unsigned second_hash(logic [KEY_W-1:0] key);
        longint unsigned digit;
        digit = (longint'(key) * DIGIT_SCALE) % DIGIT_BASE;
        return int'((TABLE_SLOTS * digit) / DIGIT_BASE);
    endfunction

    function automatic lookup_result_t apply_request(logic [OP_W-1:0] op,
                                                     logic [KEY_W-1:0] key);
        lookup_result_t res;
        int unsigned    h1;
        int unsigned    h2;
        int unsigned    moved;
        h1 = first_hash(key);
        h2 = second_hash(key);
        res = '0;
        if (first_slots[h1].valid && first_slots[h1].key == key)
        begin
            res.found      = 1'b1;
            res.slot_index = SLOT_W'(h1);
        end
        else if (second_slots[h2].valid && second_slots[h2].key == key)
        begin
            res.found       = 1'b1;
            res.which_table = 1'b1;
            res.slot_index  = SLOT_W'(h2);
        end
        if (op == OP_INSERT && !res.found)
        begin
            if (first_slots[h1].valid)
            begin
                moved = second_hash(first_slots[h1].key);
                second_slots[moved] = first_slots[h1];
            end
            first_slots[h1].key   = key;
            first_slots[h1].valid = 1'b1;
        end
        else if (op == OP_REMOVE && res.found)
        begin
            if (res.which_table)
                second_slots[res.slot_index].valid = 1'b0;
            else
                first_slots[res.slot_index].valid = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [31:0] r;
        r = $urandom();
        return r[KEY_W-1:0];
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return OP_INSERT;
        else if (pick < 65)
            return OP_REMOVE;
        else if (pick < 94)
            return OP_SEARCH;
        return OP_UNUSED;
    endfunction

    // Keys crowd onto a few first-table rows so displacements and overwrites are common.
    task automatic refill_key_pool();
        int unsigned     rows[3];
        longint unsigned stride;
        foreach (rows[i])
            rows[i] = $urandom_range(0, TABLE_SLOTS - 1);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if ($urandom_range(0, 1))
                stride = $urandom_range(0, 40);
            else
                stride = longint'($urandom()) % (KEY_SPAN / TABLE_SLOTS - 1);
            key_pool[i] = KEY_W'(stride * TABLE_SLOTS + rows[$urandom_range(0, 2)]);
        end
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        int             gap;
        lookup_result_t expected;
        gap = 0;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= key;
        do
            @(posedge clk);
        while (!req.ready);
        expected = apply_request(op, key);
        pending_results = {pending_results, expected};
    endtask

    task automatic wait_for_drain();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_basic_ops();
        send_request(OP_SEARCH, '0);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_SEARCH, KEY_MAX);
        send_request(OP_UNUSED, KEY_MAX);
        send_request(OP_REMOVE, KEY_W'(5));
        send_request(OP_SEARCH, '0);
        send_request(OP_REMOVE, KEY_MAX);
        send_request(OP_SEARCH, KEY_MAX);
    endtask

    task automatic test_displacement();
        send_request(OP_INSERT, KEY_W'(11));
        send_request(OP_SEARCH, '0);
        send_request(OP_INSERT, KEY_W'(22));
        send_request(OP_INSERT, KEY_W'(1));
        send_request(OP_INSERT, KEY_W'(12));
        send_request(OP_SEARCH, KEY_W'(11));
        send_request(OP_REMOVE, KEY_W'(1));
        send_request(OP_REMOVE, KEY_W'(1));
        send_request(OP_REMOVE, '0);
        send_request(OP_INSERT, KEY_W'(12));
        send_request(OP_UNUSED, KEY_W'(22));
        send_request(OP_REMOVE, KEY_W'(22));
        send_request(OP_REMOVE, KEY_W'(12));
    endtask

    task automatic test_backpressure();
        refill_key_pool();
        sender_steady = 1'b1;
        hold_req_seq++;
        for (int i = 0; i < 8; i++)
            send_request(random_op(), key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        sender_steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_for_drain();
        for (int i = 0; i < 6; i++)
            send_request(random_op(), key_pool[$urandom_range(0, POOL_SIZE - 1)]);
    endtask

    task automatic test_random_traffic(int count);
        logic [KEY_W-1:0] key;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
            begin
                refill_key_pool();
                sender_steady = ($urandom_range(0, 3) == 0);
                stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            end
            if ($urandom_range(0, 9) == 0)
                key = random_key();
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(random_op(), key);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req_seq != hold_ack_seq)
        begin
            hold_ack_seq = hold_req_seq;
            hold_left = LONG_HOLD;
        end
        stall_phase = (stall_phase + 1) % 8;
        if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else if (stall_mode == STALL_RANDOM)
            rsp.ready <= ($urandom_range(0, 9) >= 4);
        else if (stall_mode == STALL_PERIODIC)
            rsp.ready <= (stall_phase < 5);
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response beat found=%0b table=%0b slot=%0d",
                         $time, rsp.found, rsp.which_table, rsp.slot_index);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, rsp.found);
                    error_count++;
                end
                if (rsp.which_table !== want.which_table)
                begin
                    $display("%0t: which_table expected %0b actual %0b",
                             $time, want.which_table, rsp.which_table);
                    error_count++;
                end
                if (rsp.slot_index !== want.slot_index)
                begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot_index, rsp.slot_index);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** two_table_cuckoo_hash: FAILED **");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        burst_left    = 0;
        sender_steady = 1'b0;
        stall_mode    = STALL_RANDOM;
        stall_phase   = 0;
        hold_req_seq  = 0;
        hold_ack_seq  = 0;
        hold_left     = 0;
        foreach (first_slots[i])
        begin
            first_slots[i]  = '0;
            second_slots[i] = '0;
        end
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.op    = OP_SEARCH;
        req.key   = '0;
        rsp.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_displacement();
        test_backpressure();
        test_drain_pause();
        test_random_traffic(RANDOM_ITEMS);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** two_table_cuckoo_hash: PASSED **");
        else
            $display("** two_table_cuckoo_hash: FAILED **");
        $finish;
    end

endmodule
